[rtl/nmea_gga_position_parser_assert.svh]
// Assertion macros shared by the checker of the GGA position parser.
// Depends on nothing; included by the checker file.
`ifndef NMEA_GGA_POSITION_PARSER_ASSERT_SVH
`define NMEA_GGA_POSITION_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NGGA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ngga assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NGGA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ngga assertion failed");

`endif

[rtl/ngga_pkg.sv]
// Types, character codes and per-byte update functions of the GGA parser.
// Depends on nothing; used by ngga_step, the parser top level and the checker.
package ngga_pkg;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_N      = 8'h4E;
    localparam logic [7:0] CHAR_S      = 8'h53;
    localparam logic [7:0] CHAR_E      = 8'h45;
    localparam logic [7:0] CHAR_W      = 8'h57;
    localparam logic [7:0] CHAR_ZERO   = 8'd48;
    localparam logic [7:0] CHAR_NINE   = 8'd57;
    localparam logic [7:0] CHAR_G      = 8'h47;
    localparam logic [7:0] CHAR_P      = 8'h50;
    localparam logic [7:0] CHAR_A      = 8'h41;

    localparam logic [2:0] TAG_LEN = 3'd5;

    localparam logic [2:0] FIELD_HEAD = 3'd0;
    localparam logic [2:0] FIELD_TIME = 3'd1;
    localparam logic [2:0] FIELD_LAT  = 3'd2;
    localparam logic [2:0] FIELD_NS   = 3'd3;
    localparam logic [2:0] FIELD_LON  = 3'd4;
    localparam logic [2:0] FIELD_EW   = 3'd5;
    localparam logic [2:0] FIELD_REST = 3'd6;

    localparam logic [3:0] TIME_LEN = 4'd10;
    localparam logic [3:0] TIME_DOT = 4'd6;
    localparam logic [3:0] LAT_LEN  = 4'd9;
    localparam logic [3:0] LAT_DOT  = 4'd4;
    localparam logic [3:0] LON_LEN  = 4'd10;
    localparam logic [3:0] LON_DOT  = 4'd5;
    localparam logic [3:0] CHAR_POS_MAX = 4'd15;

    localparam int FLAG_TIME = 0;
    localparam int FLAG_LAT  = 1;
    localparam int FLAG_NS   = 2;
    localparam int FLAG_LON  = 3;
    localparam int FLAG_EW   = 4;

    localparam logic [1:0] STATUS_GOOD     = 2'd0;
    localparam logic [1:0] STATUS_POS_BAD  = 2'd1;
    localparam logic [1:0] STATUS_TIME_BAD = 2'd2;

    localparam logic [1:0] DIR_FIRST   = 2'd0;
    localparam logic [1:0] DIR_SECOND  = 2'd1;
    localparam logic [1:0] DIR_INVALID = 2'd2;

    typedef struct packed {
        logic        in_sentence;
        logic [2:0]  prefix_pos;
        logic        prefix_match;
        logic [2:0]  field_index;
        logic [3:0]  char_pos;
        logic        fmt_ok;
        logic [35:0] digit_shift;
        logic [7:0]  dir_char;
        logic [35:0] time_hold;
        logic [31:0] lat_hold;
        logic [35:0] lon_hold;
        logic [4:0]  field_flags;
        logic        lat_south;
        logic        lon_west;
    } state_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [35:0] time_bcd;
        logic [31:0] lat_bcd;
        logic        lat_ok;
        logic [1:0]  lat_dir;
        logic [35:0] lon_bcd;
        logic        lon_ok;
        logic [1:0]  lon_dir;
    } rec_t;

    localparam state_t STATE_RESET = '{fmt_ok: 1'b1, default: '0};
    localparam state_t SENTENCE_OPEN =
        '{in_sentence: 1'b1, prefix_match: 1'b1, fmt_ok: 1'b1, default: '0};

    function automatic logic [7:0] tag_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = CHAR_G;
            3'd1:    c = CHAR_P;
            3'd2:    c = CHAR_G;
            3'd3:    c = CHAR_G;
            3'd4:    c = CHAR_A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic state_t field_clear(input state_t st);
        state_t s;
        s = st;
        s.char_pos    = '0;
        s.fmt_ok      = 1'b1;
        s.digit_shift = '0;
        s.dir_char    = '0;
        return s;
    endfunction

    function automatic state_t field_close(input state_t st);
        state_t s;
        s = st;
        unique case (s.field_index)
            FIELD_TIME:
            begin
                if (s.fmt_ok && s.char_pos == TIME_LEN)
                begin
                    s.field_flags[FLAG_TIME] = 1'b1;
                    s.time_hold = s.digit_shift;
                end
            end
            FIELD_LAT:
            begin
                if (s.fmt_ok && s.char_pos == LAT_LEN)
                begin
                    s.field_flags[FLAG_LAT] = 1'b1;
                    s.lat_hold = s.digit_shift[31:0];
                end
            end
            FIELD_NS:
            begin
                if (s.char_pos != 4'd0 && (s.dir_char == CHAR_N || s.dir_char == CHAR_S))
                begin
                    s.field_flags[FLAG_NS] = 1'b1;
                    s.lat_south = (s.dir_char == CHAR_S);
                end
            end
            FIELD_LON:
            begin
                if (s.fmt_ok && s.char_pos == LON_LEN)
                begin
                    s.field_flags[FLAG_LON] = 1'b1;
                    s.lon_hold = s.digit_shift;
                end
            end
            FIELD_EW:
            begin
                if (s.char_pos != 4'd0 && (s.dir_char == CHAR_E || s.dir_char == CHAR_W))
                begin
                    s.field_flags[FLAG_EW] = 1'b1;
                    s.lon_west = (s.dir_char == CHAR_W);
                end
            end
            default:
            begin
            end
        endcase
        return s;
    endfunction

    function automatic state_t numeric_char(input state_t st, input logic [7:0] b,
                                            input logic [3:0] len, input logic [3:0] dot);
        state_t s;
        logic   digit;
        s = st;
        digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        if (s.char_pos >= len)
        begin
            s.fmt_ok = 1'b0;
        end
        else if (s.char_pos == dot)
        begin
            if (b != CHAR_DOT)
            begin
                s.fmt_ok = 1'b0;
            end
        end
        else if (digit)
        begin
            s.digit_shift = {s.digit_shift[31:0], b[3:0]};
        end
        else
        begin
            s.fmt_ok = 1'b0;
        end
        return s;
    endfunction

    function automatic state_t content_byte(input state_t st, input logic [7:0] b);
        state_t s;
        s = st;
        if (s.prefix_pos < TAG_LEN)
        begin
            if (b != tag_char(s.prefix_pos))
            begin
                s.prefix_match = 1'b0;
            end
            s.prefix_pos = s.prefix_pos + 3'd1;
        end
        if (b == CHAR_COMMA)
        begin
            s = field_close(s);
            if (s.field_index < FIELD_REST)
            begin
                s.field_index = s.field_index + 3'd1;
            end
            s = field_clear(s);
        end
        else
        begin
            unique case (s.field_index)
                FIELD_TIME: s = numeric_char(s, b, TIME_LEN, TIME_DOT);
                FIELD_LAT:  s = numeric_char(s, b, LAT_LEN, LAT_DOT);
                FIELD_LON:  s = numeric_char(s, b, LON_LEN, LON_DOT);
                FIELD_NS, FIELD_EW:
                begin
                    if (s.char_pos == 4'd0)
                    begin
                        s.dir_char = b;
                    end
                end
                default:
                begin
                end
            endcase
            if (s.char_pos < CHAR_POS_MAX)
            begin
                s.char_pos = s.char_pos + 4'd1;
            end
        end
        return s;
    endfunction

    function automatic logic is_gga(input state_t s);
        return s.in_sentence && s.prefix_pos == TAG_LEN && s.prefix_match;
    endfunction

    function automatic rec_t build_record(input state_t s);
        rec_t r;
        r.lat_ok = s.field_flags[FLAG_LAT];
        r.lon_ok = s.field_flags[FLAG_LON];
        if (!s.field_flags[FLAG_TIME])
        begin
            r.status = STATUS_TIME_BAD;
        end
        else if (s.field_flags[FLAG_EW:FLAG_LAT] != 4'hF)
        begin
            r.status = STATUS_POS_BAD;
        end
        else
        begin
            r.status = STATUS_GOOD;
        end
        r.time_bcd = s.field_flags[FLAG_TIME] ? s.time_hold : 36'd0;
        r.lat_bcd  = r.lat_ok ? s.lat_hold : 32'd0;
        r.lon_bcd  = r.lon_ok ? s.lon_hold : 36'd0;
        if (!s.field_flags[FLAG_NS])
        begin
            r.lat_dir = DIR_INVALID;
        end
        else
        begin
            r.lat_dir = s.lat_south ? DIR_SECOND : DIR_FIRST;
        end
        if (!s.field_flags[FLAG_EW])
        begin
            r.lon_dir = DIR_INVALID;
        end
        else
        begin
            r.lon_dir = s.lon_west ? DIR_SECOND : DIR_FIRST;
        end
        return r;
    endfunction

endpackage

[rtl/ngga_if.sv]
// Valid/ready channel interfaces of the GGA parser: the byte stream in and
// the position record out. Depends on nothing.
interface ngga_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface ngga_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [35:0] time_bcd;
    logic [31:0] lat_bcd;
    logic        lat_ok;
    logic [1:0]  lat_dir;
    logic [35:0] lon_bcd;
    logic        lon_ok;
    logic [1:0]  lon_dir;

    modport source (output valid, output status, output time_bcd, output lat_bcd,
                    output lat_ok, output lat_dir, output lon_bcd, output lon_ok,
                    output lon_dir, input ready);
    modport sink (input valid, input status, input time_bcd, input lat_bcd,
                  input lat_ok, input lat_dir, input lon_bcd, input lon_ok,
                  input lon_dir, output ready);
endinterface

[rtl/ngga_step.sv]
// Per-byte update of the GGA parser: next sentence state and closing record.
// Depends on ngga_pkg.
module ngga_step (
    input  ngga_pkg::state_t cur,
    input  logic [7:0]       data_byte,
    input  logic             end_of_buffer,
    output ngga_pkg::state_t nxt,
    output logic             emit,
    output ngga_pkg::rec_t   rec
);
    import ngga_pkg::*;

    state_t close_src;
    logic   is_dollar;

    always_comb
    begin
        is_dollar = (data_byte == CHAR_DOLLAR);
        if (is_dollar)
        begin
            close_src = cur;
            nxt       = SENTENCE_OPEN;
        end
        else if (cur.in_sentence)
        begin
            close_src = content_byte(cur, data_byte);
            nxt       = close_src;
        end
        else
        begin
            close_src = cur;
            nxt       = cur;
        end
        if (end_of_buffer)
        begin
            nxt.in_sentence = 1'b0;
        end
        emit = is_gga(close_src) && (is_dollar || end_of_buffer);
        rec  = build_record(field_close(close_src));
    end

endmodule

[rtl/nmea_gga_position_parser.sv]
// Top level of the GGA position parser: sentence state, result register, skid.
// Depends on ngga_pkg, ngga_if and ngga_step.
//
// The stream channel takes one NMEA character per beat, with end_of_buffer
// marking the last character of a buffer. A sentence opens at '$' and closes
// at the next '$' or at a beat marked end_of_buffer; a closing GPGGA sentence
// yields one record beat on the result channel.
// Throughput is one character per cycle while stream.ready is high. Records
// come from a result register, entering the skid register first if it is full.
// Reset clears the sentence state, so characters are ignored until a '$'
// arrives, and empties the result and skid registers.
// When the receiver stalls, characters that close no sentence keep flowing;
// one further record is held in a skid register, and stream.ready falls only
// while both the result and the skid register are full.
module nmea_gga_position_parser (
    input  logic          clk,
    input  logic          rst_n,
    ngga_byte_if.sink     stream,
    ngga_rec_if.source    result
);
    import ngga_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   emit;
    rec_t   rec;
    logic   accept;
    logic   push;
    logic   out_free;

    logic   out_valid_reg;
    logic   out_valid_next;
    rec_t   out_rec_reg;
    rec_t   out_rec_next;
    logic   skid_valid_reg;
    logic   skid_valid_next;
    rec_t   skid_rec_reg;
    rec_t   skid_rec_next;

    ngga_step u_step (
        .cur           (state_reg),
        .data_byte     (stream.data_byte),
        .end_of_buffer (stream.end_of_buffer),
        .nxt           (state_next),
        .emit          (emit),
        .rec           (rec)
    );

    assign stream.ready = !skid_valid_reg;
    assign accept       = stream.valid && stream.ready;
    assign push         = accept && emit;
    assign out_free     = !out_valid_reg || result.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_rec_next    = out_rec_reg;
        skid_valid_next = skid_valid_reg;
        skid_rec_next   = skid_rec_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_rec_next    = skid_rec_reg;
                skid_valid_next = push;
                skid_rec_next   = rec;
            end
            else
            begin
                out_valid_next = push;
                out_rec_next   = rec;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_rec_next   = rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= STATE_RESET;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rec_reg  <= out_rec_next;
        skid_rec_reg <= skid_rec_next;
    end

    assign result.valid    = out_valid_reg;
    assign result.status   = out_rec_reg.status;
    assign result.time_bcd = out_rec_reg.time_bcd;
    assign result.lat_bcd  = out_rec_reg.lat_bcd;
    assign result.lat_ok   = out_rec_reg.lat_ok;
    assign result.lat_dir  = out_rec_reg.lat_dir;
    assign result.lon_bcd  = out_rec_reg.lon_bcd;
    assign result.lon_ok   = out_rec_reg.lon_ok;
    assign result.lon_dir  = out_rec_reg.lon_dir;

endmodule

[rtl/ngga_checker.sv]
// Port-level checks of the GGA position parser and the bind that attaches them.
// Depends on ngga_pkg and nmea_gga_position_parser_assert.svh.
`include "nmea_gga_position_parser_assert.svh"

module ngga_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [35:0] time_bcd,
    input logic [31:0] lat_bcd,
    input logic        lat_ok
);
    import ngga_pkg::*;

    // A stalled record stays on offer with the same contents.
    `NGGA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(status) && $stable(time_bcd) && $stable(lat_bcd))

    // A new record only ever follows an accepted character.
    `NGGA_ASSERT_IMP(a_rec_after_beat, clk, rst_n, $rose(out_valid),
        $past(in_valid && in_ready))

    // Back-pressure on the stream only while a record is waiting.
    `NGGA_ASSERT_IMP(a_stall_needs_rec, clk, rst_n, !in_ready, out_valid)

    // Rejected times and bad latitudes carry cleared digits.
    `NGGA_ASSERT_IMP(a_cleared_digits, clk, rst_n, out_valid,
        (status != STATUS_TIME_BAD || time_bcd == 36'd0) && (lat_ok || lat_bcd == 32'd0))

endmodule

bind nmea_gga_position_parser ngga_checker u_ngga_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (stream.valid),
    .in_ready  (stream.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (result.status),
    .time_bcd  (result.time_bcd),
    .lat_bcd   (result.lat_bcd),
    .lat_ok    (result.lat_ok)
);

[dv/tb_nmea_gga_position_parser.sv]
// Testbench for nmea_gga_position_parser: streams NMEA sentences in, checks every GGA record.
// Depends on ngga_pkg, the ngga_byte_if and ngga_rec_if interfaces and the parser top level.
// Records are compared with a built-in sentence predictor and with hand-written expectations.
`timescale 1ns / 1ps

module tb_nmea_gga_position_parser;
    import ngga_pkg::*;

    localparam int    HOLD_CYCLES = 300;
    localparam int    STALL_LIMIT = 2000;
    localparam int    PHASE_BEATS = 180;
    localparam string GGA_TAG     = "GPGGA";

    typedef struct {
        string text;
        bit    close_eob;
        bit    typed;
        rec_t  want;
    } sentence_row_t;

    logic clk;
    logic rst_n = 1'b0;

    ngga_byte_if stream_ch ();
    ngga_rec_if  result_ch ();

    nmea_gga_position_parser dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .result (result_ch)
    );

    // Predicted parser state.
    bit        sn_open    = 1'b0;
    bit [2:0]  sn_tag_pos = '0;
    bit        sn_tag_ok  = 1'b0;
    bit [2:0]  sn_field   = '0;
    bit [3:0]  sn_len     = '0;
    bit        sn_fmt_ok  = 1'b1;
    bit [35:0] sn_digits  = '0;
    bit [7:0]  sn_first   = '0;
    bit [35:0] sn_time    = '0;
    bit [31:0] sn_lat     = '0;
    bit [35:0] sn_lon     = '0;
    bit [4:0]  sn_good    = '0;
    bit        sn_south   = 1'b0;
    bit        sn_west    = 1'b0;

    rec_t          fix_q[$];
    bit [7:0]      line_q[$];
    sentence_row_t directed_rows[$];

    int fail_count     = 0;
    int beats_accepted = 0;
    int fixes_expected = 0;
    int status_seen[3] = '{0, 0, 0};
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    bit hold_request   = 1'b0;
    int idle_run;

    function automatic void clear_field();
        sn_len    = '0;
        sn_fmt_ok = 1'b1;
        sn_digits = '0;
        sn_first  = '0;
    endfunction

    function automatic void close_field();
        case (sn_field)
            FIELD_TIME:
            begin
                if (sn_fmt_ok && sn_len == TIME_LEN)
                begin
                    sn_good[FLAG_TIME] = 1'b1;
                    sn_time = sn_digits;
                end
            end
            FIELD_LAT:
            begin
                if (sn_fmt_ok && sn_len == LAT_LEN)
                begin
                    sn_good[FLAG_LAT] = 1'b1;
                    sn_lat = sn_digits[31:0];
                end
            end
            FIELD_NS:
            begin
                if (sn_len != 0 && (sn_first == CHAR_N || sn_first == CHAR_S))
                begin
                    sn_good[FLAG_NS] = 1'b1;
                    sn_south = (sn_first == CHAR_S);
                end
            end
            FIELD_LON:
            begin
                if (sn_fmt_ok && sn_len == LON_LEN)
                begin
                    sn_good[FLAG_LON] = 1'b1;
                    sn_lon = sn_digits;
                end
            end
            FIELD_EW:
            begin
                if (sn_len != 0 && (sn_first == CHAR_E || sn_first == CHAR_W))
                begin
                    sn_good[FLAG_EW] = 1'b1;
                    sn_west = (sn_first == CHAR_W);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void shift_digit(input bit [7:0] b, input bit [3:0] len,
                                        input bit [3:0] dot);
        if (sn_len >= len)
        begin
            sn_fmt_ok = 1'b0;
        end
        else if (sn_len == dot)
        begin
            if (b != CHAR_DOT)
            begin
                sn_fmt_ok = 1'b0;
            end
        end
        else if (b >= CHAR_ZERO && b <= CHAR_NINE)
        begin
            sn_digits = {sn_digits[31:0], b[3:0]};
        end
        else
        begin
            sn_fmt_ok = 1'b0;
        end
    endfunction

    function automatic bit emit_fix(output rec_t r);
        r = '0;
        if (!(sn_open && sn_tag_pos == TAG_LEN && sn_tag_ok))
        begin
            return 1'b0;
        end
        close_field();
        r.lat_ok = sn_good[FLAG_LAT];
        r.lon_ok = sn_good[FLAG_LON];
        if (!sn_good[FLAG_TIME])
        begin
            r.status = STATUS_TIME_BAD;
        end
        else if (sn_good[FLAG_EW:FLAG_LAT] != 4'hF)
        begin
            r.status = STATUS_POS_BAD;
        end
        else
        begin
            r.status = STATUS_GOOD;
        end
        r.time_bcd = (r.status != STATUS_TIME_BAD) ? sn_time : 36'd0;
        r.lat_bcd  = r.lat_ok ? sn_lat : 32'd0;
        r.lon_bcd  = r.lon_ok ? sn_lon : 36'd0;
        r.lat_dir  = !sn_good[FLAG_NS] ? DIR_INVALID : (sn_south ? DIR_SECOND : DIR_FIRST);
        r.lon_dir  = !sn_good[FLAG_EW] ? DIR_INVALID : (sn_west ? DIR_SECOND : DIR_FIRST);
        return 1'b1;
    endfunction

    function automatic bit predict_fix(input bit [7:0] b, input bit eob, output rec_t r);
        bit       got;
        bit [7:0] tag_ch;
        got = 1'b0;
        r = '0;
        if (b == CHAR_DOLLAR)
        begin
            got = emit_fix(r);
            sn_open    = 1'b1;
            sn_tag_pos = '0;
            sn_tag_ok  = 1'b1;
            sn_field   = FIELD_HEAD;
            clear_field();
            sn_time  = '0;
            sn_lat   = '0;
            sn_lon   = '0;
            sn_good  = '0;
            sn_south = 1'b0;
            sn_west  = 1'b0;
        end
        else if (sn_open)
        begin
            if (sn_tag_pos < TAG_LEN)
            begin
                tag_ch = GGA_TAG[sn_tag_pos];
                if (b != tag_ch)
                begin
                    sn_tag_ok = 1'b0;
                end
                sn_tag_pos++;
            end
            if (b == CHAR_COMMA)
            begin
                close_field();
                if (sn_field < FIELD_REST)
                begin
                    sn_field++;
                end
                clear_field();
            end
            else
            begin
                case (sn_field)
                    FIELD_TIME: shift_digit(b, TIME_LEN, TIME_DOT);
                    FIELD_LAT:  shift_digit(b, LAT_LEN, LAT_DOT);
                    FIELD_LON:  shift_digit(b, LON_LEN, LON_DOT);
                    FIELD_NS, FIELD_EW:
                    begin
                        if (sn_len == 0)
                        begin
                            sn_first = b;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (sn_len < CHAR_POS_MAX)
                begin
                    sn_len++;
                end
            end
        end
        if (eob)
        begin
            if (!got)
            begin
                got = emit_fix(r);
            end
            sn_open = 1'b0;
        end
        return got;
    endfunction

    function automatic rec_t typed_fix(input logic [1:0] st, input logic [35:0] tm,
                                       input logic [31:0] la, input bit la_ok,
                                       input logic [1:0] la_dir, input logic [35:0] lo,
                                       input bit lo_ok, input logic [1:0] lo_dir);
        rec_t r;
        r = '{status: st, time_bcd: tm, lat_bcd: la, lat_ok: la_ok, lat_dir: la_dir,
              lon_bcd: lo, lon_ok: lo_ok, lon_dir: lo_dir};
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [35:0] want,
                                        input logic [35:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
        end
    endfunction

    function automatic bit [7:0] pick_junk();
        bit [7:0] c;
        do
        begin
            c = 8'($urandom_range(255));
        end
        while (c == CHAR_COMMA || c == CHAR_DOLLAR);
        return c;
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            line_q.push_back(s[i]);
        end
    endfunction

    function automatic void add_numeric(input int len, input int dot);
        int mode;
        int n;
        int bad_at;
        mode = $urandom_range(99);
        if (mode < 5)
        begin
            return;
        end
        n = len;
        if (mode < 10)
        begin
            n = $urandom_range(1) ? len - 1 - $urandom_range(len - 2) : len + 1 + $urandom_range(7);
        end
        bad_at = (mode >= 10 && mode < 15) ? $urandom_range(n - 1) : -1;
        for (int k = 0; k < n; k++)
        begin
            if (k == bad_at)
            begin
                line_q.push_back(pick_junk());
            end
            else if (k == dot && !(mode >= 15 && mode < 19))
            begin
                line_q.push_back(CHAR_DOT);
            end
            else
            begin
                line_q.push_back(CHAR_ZERO + 8'($urandom_range(9)));
            end
        end
    endfunction

    function automatic void add_dir(input bit [7:0] first, input bit [7:0] second);
        int mode;
        mode = $urandom_range(99);
        if (mode < 8)
        begin
            return;
        end
        if (mode < 16)
        begin
            line_q.push_back(pick_junk());
            return;
        end
        line_q.push_back($urandom_range(1) ? first : second);
        if (mode >= 92)
        begin
            repeat ($urandom_range(1, 4)) line_q.push_back(pick_junk());
        end
    endfunction

    task automatic send_line(input bit eob_last, input bit use_typed, input rec_t typed);
        rec_t fix;
        bit   got;
        bit   eob;
        for (int k = 0; k < line_q.size(); k++)
        begin
            eob = eob_last && (k == line_q.size() - 1);
            if ($urandom_range(99) < send_idle_pct)
            begin
                stream_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            stream_ch.valid         <= 1'b1;
            stream_ch.data_byte     <= line_q[k];
            stream_ch.end_of_buffer <= eob;
            do
            begin
                @(posedge clk);
            end
            while (stream_ch.ready !== 1'b1);
            beats_accepted++;
            got = predict_fix(line_q[k], eob, fix);
            if (got)
            begin
                fixes_expected++;
                fix_q.push_back((use_typed && eob) ? typed : fix);
            end
        end
        line_q.delete();
    endtask

    task automatic drain();
        stream_ch.valid <= 1'b0;
        while (fix_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic random_traffic(input int beat_target);
        int beats;
        int kind;
        int fields;
        bit eob_last;
        bit is_noise;
        beats = 0;
        while (beats < beat_target)
        begin
            kind = $urandom_range(99);
            is_noise = (kind >= 88) && !sn_open;
            eob_last = 1'($urandom_range(1));
            if (is_noise)
            begin
                repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(255)));
                eob_last = ($urandom_range(3) == 0);
            end
            else if (kind >= 74)
            begin
                case ($urandom_range(3))
                    0: add_text("$GPRMC,081836,A,3751.65,S,14507.36,E");
                    1: add_text("$GPGSV,3,1,11");
                    2: add_text("$GPGG");
                    default: add_text("$GPGGB,123519.000,4807.0380,N,01131.0000,E");
                endcase
            end
            else
            begin
                add_text("$GPGGA");
                if (kind < 5)
                begin
                    line_q[1 + $urandom_range(4)] = pick_junk();
                end
                else if (kind < 11)
                begin
                    repeat ($urandom_range(1, 3)) line_q.push_back(pick_junk());
                end
                fields = ($urandom_range(99) < 85) ? 5 : $urandom_range(4);
                if (fields > 0)
                begin
                    add_text(",");
                    add_numeric(TIME_LEN, TIME_DOT);
                end
                if (fields > 1)
                begin
                    add_text(",");
                    add_numeric(LAT_LEN, LAT_DOT);
                end
                if (fields > 2)
                begin
                    add_text(",");
                    add_dir(CHAR_N, CHAR_S);
                end
                if (fields > 3)
                begin
                    add_text(",");
                    add_numeric(LON_LEN, LON_DOT);
                end
                if (fields > 4)
                begin
                    add_text(",");
                    add_dir(CHAR_E, CHAR_W);
                    if ($urandom_range(2) == 0)
                    begin
                        add_text(",1,08,0.9,545.4,M,46.9,M,,*47");
                    end
                end
            end
            if (!is_noise)
            begin
                beats += line_q.size();
            end
            send_line(eob_last, 1'b0, '0);
            if (!is_noise && $urandom_range(9) == 0)
            begin
                add_text("$");
                send_line(1'b1, 1'b0, '0);
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    result_ch.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        rec_t got;
        rec_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = {result_ch.status, result_ch.time_bcd, result_ch.lat_bcd, result_ch.lat_ok,
                   result_ch.lat_dir, result_ch.lon_bcd, result_ch.lon_ok, result_ch.lon_dir};
            if (got.status < 3)
            begin
                status_seen[got.status]++;
            end
            if (fix_q.size() == 0)
            begin
                fail_count++;
                $display("%0t: record beat with none expected, status %0d time %h",
                         $time, got.status, got.time_bcd);
            end
            else
            begin
                want = fix_q.pop_front();
                check_field("status", 36'(want.status), 36'(got.status));
                check_field("time_bcd", want.time_bcd, got.time_bcd);
                check_field("lat_bcd", 36'(want.lat_bcd), 36'(got.lat_bcd));
                check_field("lat_ok", 36'(want.lat_ok), 36'(got.lat_ok));
                check_field("lat_dir", 36'(want.lat_dir), 36'(got.lat_dir));
                check_field("lon_bcd", want.lon_bcd, got.lon_bcd);
                check_field("lon_ok", 36'(want.lon_ok), 36'(got.lon_ok));
                check_field("lon_dir", 36'(want.lon_dir), 36'(got.lon_dir));
            end
        end
    end

    initial
    begin
        idle_run = 0;
        while (idle_run < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((stream_ch.valid && stream_ch.ready) || (result_ch.valid && result_ch.ready))
            begin
                idle_run = 0;
            end
            else
            begin
                idle_run++;
            end
        end
        $display("%0t: no beat on either channel for %0d cycles", $time, idle_run);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        stream_ch.valid         <= 1'b0;
        stream_ch.data_byte     <= '0;
        stream_ch.end_of_buffer <= 1'b0;
        send_idle_pct = 14;
        recv_idle_pct = 80;

        directed_rows.push_back('{"GPGGA,1*\r\n", 1'b1, 1'b0, '0});
        directed_rows.push_back('{"$GPGGA,123519.000,4807.0380,N,01131.0000,E", 1'b1, 1'b1,
            typed_fix(STATUS_GOOD, 36'h123519000, 32'h48070380, 1'b1, DIR_FIRST,
                      36'h011310000, 1'b1, DIR_FIRST)});
        directed_rows.push_back('{"$GPGGA,999999.999,9999.9999,S,99999.9999,W", 1'b1, 1'b1,
            typed_fix(STATUS_GOOD, 36'h999999999, 32'h99999999, 1'b1, DIR_SECOND,
                      36'h999999999, 1'b1, DIR_SECOND)});
        directed_rows.push_back('{{"$GPGGA,000000.000,0000.0000,N,00000.0000,E",
                                   ",1,08,0.9,545.4,M,46.9,M,,*47"}, 1'b1, 1'b1,
            typed_fix(STATUS_GOOD, 36'h0, 32'h0, 1'b1, DIR_FIRST, 36'h0, 1'b1, DIR_FIRST)});
        directed_rows.push_back('{"$GPGGA,,,,,", 1'b1, 1'b1,
            typed_fix(STATUS_TIME_BAD, 36'h0, 32'h0, 1'b0, DIR_INVALID,
                      36'h0, 1'b0, DIR_INVALID)});
        directed_rows.push_back('{"$GPGGA,123519.000", 1'b1, 1'b1,
            typed_fix(STATUS_POS_BAD, 36'h123519000, 32'h0, 1'b0, DIR_INVALID,
                      36'h0, 1'b0, DIR_INVALID)});
        directed_rows.push_back('{"$GPGG", 1'b1, 1'b0, '0});
        directed_rows.push_back('{"$GPRMC,123519.000,A", 1'b1, 1'b0, '0});
        directed_rows.push_back('{"$GPGGAXYZ,120000.000,1234.5678,S,12345.6789,W",
                                  1'b0, 1'b0, '0});
        directed_rows.push_back('{"$", 1'b1, 1'b0, '0});
        directed_rows.push_back('{"$GPGGA,12351.9000,48070.380,n,0113.10000,e", 1'b1, 1'b1,
            typed_fix(STATUS_TIME_BAD, 36'h0, 32'h0, 1'b0, DIR_INVALID,
                      36'h0, 1'b0, DIR_INVALID)});
        directed_rows.push_back('{"$GPGGA,123519.0000,48A7.0380,NORTH,01131.00001234567,EAST",
                                  1'b0, 1'b0, '0});
        directed_rows.push_back('{"$GPGGA,235959.999,8959.9999,,17959.9999,", 1'b1, 1'b0, '0});
        directed_rows.push_back('{"$GPGGB,123519.000,4807.0380,N,01131.0000,E", 1'b1, 1'b0, '0});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            add_text(directed_rows[i].text);
            send_line(directed_rows[i].close_eob, directed_rows[i].typed, directed_rows[i].want);
        end
        random_traffic(PHASE_BEATS);
        drain();

        send_idle_pct = 80;
        recv_idle_pct = 14;
        random_traffic(PHASE_BEATS);
        drain();

        // The result side holds off while short sentences keep arriving, so the block fills.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        repeat (12)
        begin
            add_text("$GPGGA,");
            add_numeric(TIME_LEN, TIME_DOT);
            send_line(1'b1, 1'b0, '0);
        end
        drain();
        random_traffic(PHASE_BEATS);
        drain();

        $display("Covered %0d stream beats and %0d records: %0d good, %0d position bad,",
                 beats_accepted, fixes_expected, status_seen[0], status_seen[1]);
        $display("%0d time bad, over three idling mixes and one long result stall.",
                 status_seen[2]);
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
